FILE: rtl/sla_pkg.sv
// Shared types and character codes for the serial line assembler.
package sla_pkg;

    localparam logic [2:0] REQ_RX      = 3'd0;
    localparam logic [2:0] REQ_TX_RDY  = 3'd1;
    localparam logic [2:0] REQ_PUSH    = 3'd2;
    localparam logic [2:0] REQ_RELEASE = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_GT = 8'h3E;
    localparam logic [7:0] CHAR_L  = 8'h4C;

    // Longest burst of bytes one received word can queue into the ring.
    localparam int MSG_MAX = 5;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } ring_cmd_t;

    typedef struct packed {
        logic       store;
        logic       release_line;
        logic       read;
        logic [7:0] data;
        logic [5:0] rd_index;
    } line_cmd_t;

    typedef struct packed {
        logic pending;
        logic completed_second;
        logic at_last;
    } line_stat_t;

endpackage

FILE: rtl/sla_tx_ring.sv
// Transmit ring: byte memory with head, tail and fill count.
module sla_tx_ring #(
    parameter int TX_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sla_pkg::ring_cmd_t           cmd,
    output logic [7:0]                   rd_data,
    output logic [$clog2(TX_DEPTH+1)-1:0] count
);
    import sla_pkg::*;

    localparam int PW = $clog2(TX_DEPTH);
    localparam int CW = $clog2(TX_DEPTH + 1);

    logic [7:0]    mem [TX_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    rd_reg;
    logic          do_push;
    logic          do_pop;

    // A push into a full ring is dropped.
    assign do_push = cmd.push && (count_reg != CW'(TX_DEPTH));
    assign do_pop  = cmd.pop && (count_reg != '0);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push) begin
            tail_next  = (tail_reg == PW'(TX_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            count_next = count_reg + CW'(1);
        end else if (do_pop) begin
            head_next  = (head_reg == PW'(TX_DEPTH - 1)) ? '0 : head_reg + PW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= cmd.data;
        end
        if (do_pop) begin
            rd_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_reg;
    assign count   = count_reg;

endmodule

FILE: rtl/sla_line_buf.sv
// Double line store: one memory holding both lines plus fill and handover state.
module sla_line_buf #(
    parameter int LINE_LAST = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sla_pkg::line_cmd_t  cmd,
    output sla_pkg::line_stat_t stat,
    output logic [7:0]          rd_data
);
    import sla_pkg::*;

    localparam int LW = $clog2(LINE_LAST + 1);

    // The upper address bit selects the store, the lower bits the position.
    logic [7:0]    mem [2**(LW+1)];
    logic [LW-1:0] pos_reg, pos_next;
    logic          filling_reg, filling_next;
    logic          completed_reg, completed_next;
    logic          pending_reg, pending_next;
    logic [7:0]    data_reg;
    logic          in_range_reg;
    logic          at_last;
    logic          in_range;

    assign at_last  = (pos_reg == LW'(LINE_LAST));
    assign in_range = (32'(cmd.rd_index) <= LINE_LAST);

    always_comb begin
        pos_next       = pos_reg;
        filling_next   = filling_reg;
        completed_next = completed_reg;
        pending_next   = pending_reg;
        if (cmd.store) begin
            if (cmd.data == 8'd0) begin
                pos_next = '0;
                if (!pending_reg) begin
                    completed_next = filling_reg;
                    filling_next   = !filling_reg;
                    pending_next   = 1'b1;
                end
            end else begin
                pos_next = at_last ? '0 : pos_reg + LW'(1);
            end
        end else if (cmd.release_line) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            filling_reg   <= 1'b0;
            completed_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            filling_reg   <= filling_next;
            completed_reg <= completed_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[{filling_reg, pos_reg}] <= cmd.data;
        end
        if (cmd.read) begin
            data_reg     <= mem[{completed_reg, LW'(cmd.rd_index)}];
            in_range_reg <= in_range;
        end
    end

    assign rd_data = in_range_reg ? data_reg : 8'd0;

    assign stat.pending          = pending_reg;
    assign stat.completed_second = completed_reg;
    assign stat.at_last          = at_last;

endmodule

FILE: rtl/serial_line_assembler_with_tx_ring_unit.sv
// Top level of the serial line assembler: request decode, ring sequencer, result register.
//
// Each request word is taken while the sequencer is idle, then queues its bytes into the
// transmit ring (none to five), one byte per cycle, and then posts its result; the single
// write port of the ring memory sets that pace. Posting waits while the previous result
// is still held on m_valid without m_ready. A new word can be taken in the cycle after its
// predecessor posts, so no word is taken while the previous one is still in progress.
// Line bytes and ring bytes live in synchronous memories, so a read of a line position
// or of the ring head is answered from a registered read taken when the word is accepted.
// Line positions never written since reset read back as undefined data.
module serial_line_assembler_with_tx_ring_unit #(
    parameter int LINE_LAST = 63,
    parameter int TX_DEPTH  = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic       s_rx_fault,
    input  logic [7:0] s_push_byte,
    input  logic [5:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_line_ready,
    output logic       m_ready_store,
    output logic [7:0] m_line_data,
    output logic [6:0] m_free_space,
    output logic       m_tx_pending
);
    import sla_pkg::*;

    localparam int CW = $clog2(TX_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic          state_reg, state_next;
    logic          echo_reg;
    logic [7:0]    msg_reg [MSG_MAX];
    logic [7:0]    msg_next [MSG_MAX];
    logic [2:0]    cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;
    logic          txv_reg, txv_next;
    logic          is_read_reg, is_read_next;
    logic          out_load;
    logic          accept;

    ring_cmd_t     ring_cmd;
    line_cmd_t     line_cmd;
    line_stat_t    line_stat;
    logic [7:0]    ring_rd_data;
    logic [7:0]    line_rd_data;
    logic [CW-1:0] ring_count;
    logic [CW-1:0] space;

    logic          m_valid_reg;
    logic          tx_valid_reg;
    logic [7:0]    tx_byte_reg;
    logic          line_ready_reg;
    logic          ready_store_reg;
    logic [7:0]    line_data_reg;
    logic [6:0]    free_space_reg;
    logic          tx_pending_reg;

    sla_tx_ring #(
        .TX_DEPTH(TX_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ring_cmd),
        .rd_data (ring_rd_data),
        .count   (ring_count)
    );

    sla_line_buf #(
        .LINE_LAST(LINE_LAST)
    ) u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (line_cmd),
        .stat    (line_stat),
        .rd_data (line_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign space   = CW'(TX_DEPTH) - ring_count;

    always_comb begin
        logic [7:0] b;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        txv_next     = txv_reg;
        is_read_next = is_read_reg;
        msg_next     = msg_reg;
        ring_cmd     = '0;
        line_cmd     = '0;
        out_load     = 1'b0;
        b            = (s_rx_byte == CHAR_CR) ? 8'd0 : s_rx_byte;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_RUN;
                    cnt_next     = 3'd0;
                    idx_next     = 3'd0;
                    txv_next     = 1'b0;
                    is_read_next = 1'b0;
                    unique case (s_req_type)
                        REQ_RX: begin
                            if (!s_rx_fault) begin
                                line_cmd.store = 1'b1;
                                line_cmd.data  = b;
                                if (s_rx_byte == CHAR_CR && echo_reg) begin
                                    msg_next[cnt_next] = CHAR_CR;
                                    cnt_next           = cnt_next + 3'd1;
                                    msg_next[cnt_next] = CHAR_LF;
                                    cnt_next           = cnt_next + 3'd1;
                                end
                                if (b == 8'd0) begin
                                    // Overrun: the other line has not been released.
                                    if (line_stat.pending) begin
                                        if (!echo_reg) begin
                                            msg_next[cnt_next] = CHAR_LT;
                                            cnt_next           = cnt_next + 3'd1;
                                        end
                                        msg_next[cnt_next] = CHAR_O;
                                        cnt_next           = cnt_next + 3'd1;
                                        msg_next[cnt_next] = CHAR_GT;
                                        cnt_next           = cnt_next + 3'd1;
                                    end
                                end else begin
                                    if (echo_reg) begin
                                        msg_next[cnt_next] = b;
                                        cnt_next           = cnt_next + 3'd1;
                                    end
                                    if (line_stat.at_last) begin
                                        if (echo_reg) begin
                                            msg_next[cnt_next] = CHAR_CR;
                                            cnt_next           = cnt_next + 3'd1;
                                            msg_next[cnt_next] = CHAR_LF;
                                            cnt_next           = cnt_next + 3'd1;
                                        end else begin
                                            msg_next[cnt_next] = CHAR_LT;
                                            cnt_next           = cnt_next + 3'd1;
                                        end
                                        msg_next[cnt_next] = CHAR_L;
                                        cnt_next           = cnt_next + 3'd1;
                                        msg_next[cnt_next] = CHAR_GT;
                                        cnt_next           = cnt_next + 3'd1;
                                    end
                                end
                            end
                        end
                        REQ_TX_RDY: begin
                            if (ring_count != '0) begin
                                ring_cmd.pop = 1'b1;
                                txv_next     = 1'b1;
                            end
                        end
                        REQ_PUSH: begin
                            msg_next[0] = s_push_byte;
                            cnt_next    = 3'd1;
                        end
                        REQ_RELEASE: begin
                            line_cmd.release_line = 1'b1;
                        end
                        REQ_READ: begin
                            line_cmd.read     = 1'b1;
                            line_cmd.rd_index = s_read_index;
                            is_read_next      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (idx_reg != cnt_reg) begin
                    ring_cmd.push = 1'b1;
                    ring_cmd.data = msg_reg[idx_reg];
                    idx_next      = idx_reg + 3'd1;
                end else if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            echo_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                echo_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg     <= msg_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        txv_reg     <= txv_next;
        is_read_reg <= is_read_next;
        if (out_load) begin
            tx_valid_reg    <= txv_reg;
            tx_byte_reg     <= txv_reg ? ring_rd_data : 8'd0;
            line_ready_reg  <= line_stat.pending;
            ready_store_reg <= line_stat.completed_second;
            line_data_reg   <= is_read_reg ? line_rd_data : 8'd0;
            free_space_reg  <= 7'(space);
            tx_pending_reg  <= (ring_count != '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tx_valid    = tx_valid_reg;
    assign m_tx_byte     = tx_byte_reg;
    assign m_line_ready  = line_ready_reg;
    assign m_ready_store = ready_store_reg;
    assign m_line_data   = line_data_reg;
    assign m_free_space  = free_space_reg;
    assign m_tx_pending  = tx_pending_reg;

endmodule

FILE: dv/tb_serial_line_assembler_with_tx_ring_unit.sv
// Self-checking testbench for the serial line assembler with transmit ring.
module tb_serial_line_assembler_with_tx_ring_unit;
    import sla_pkg::*;

    localparam int LINE_LAST = 63;
    localparam int TX_DEPTH  = 64;
    localparam int RANDOM_PER_PHASE = 242;
    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct {
        logic [2:0] req_type;
        logic [7:0] rx_byte;
        logic       rx_fault;
        logic [7:0] push_byte;
        logic [5:0] read_index;
    } req_word_t;

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       line_ready;
        logic       ready_store;
        logic [7:0] line_data;
        logic [6:0] free_space;
        logic       tx_pending;
    } status_t;

    // Tracks the line stores and the transmit ring and holds the status words still due.
    class line_ring_model;
        bit          echo_on = 1'b1;
        logic [7:0]  line_mem [0:1][0:LINE_LAST];
        bit          line_written [0:1][0:LINE_LAST];
        logic [5:0]  fill_pos = '0;
        bit          filling_second;
        bit          completed_second;
        bit          line_pending;
        logic [7:0]  tx_fifo [$];
        status_t     expected_status [$];
        int unsigned errors;
        int unsigned results_seen;

        function void ring_put(logic [7:0] b);
            // A full ring silently drops the byte.
            if (tx_fifo.size() < TX_DEPTH) begin
                tx_fifo.push_back(b);
            end
        endfunction

        function void take_rx(logic [7:0] b);
            logic [7:0] v;
            v = b;
            if (b == CHAR_CR) begin
                v = CHAR_NUL;
                if (echo_on) begin
                    ring_put(CHAR_CR);
                    ring_put(CHAR_LF);
                end
            end
            line_mem[filling_second][fill_pos] = v;
            line_written[filling_second][fill_pos] = 1'b1;
            if (v == CHAR_NUL) begin
                fill_pos = '0;
                if (line_pending) begin
                    // The other line has not been released, so this one is lost.
                    if (!echo_on) begin
                        ring_put(CHAR_LT);
                    end
                    ring_put(CHAR_O);
                    ring_put(CHAR_GT);
                end else begin
                    completed_second = filling_second;
                    filling_second   = !filling_second;
                    line_pending     = 1'b1;
                end
            end else begin
                if (echo_on) begin
                    ring_put(v);
                end
                if (fill_pos == LINE_LAST) begin
                    fill_pos = '0;
                    if (echo_on) begin
                        ring_put(CHAR_CR);
                        ring_put(CHAR_LF);
                    end else begin
                        ring_put(CHAR_LT);
                    end
                    ring_put(CHAR_L);
                    ring_put(CHAR_GT);
                end else begin
                    fill_pos = fill_pos + 6'd1;
                end
            end
        endfunction

        function void note_word(req_word_t w);
            status_t s;
            s.tx_valid  = 1'b0;
            s.tx_byte   = '0;
            s.line_data = '0;
            case (w.req_type)
                REQ_RX: begin
                    if (!w.rx_fault) begin
                        take_rx(w.rx_byte);
                    end
                end
                REQ_TX_RDY: begin
                    if (tx_fifo.size() != 0) begin
                        s.tx_valid = 1'b1;
                        s.tx_byte  = tx_fifo.pop_front();
                    end
                end
                REQ_PUSH: ring_put(w.push_byte);
                REQ_RELEASE: line_pending = 1'b0;
                REQ_READ: s.line_data = line_mem[completed_second][w.read_index];
                default: ;
            endcase
            s.line_ready  = line_pending;
            s.ready_store = completed_second;
            s.free_space  = 7'(TX_DEPTH - tx_fifo.size());
            s.tx_pending  = (tx_fifo.size() != 0);
            expected_status.push_back(s);
        endfunction

        // Finds a position of the completed store that has been written since reset.
        function bit find_read_index(output logic [5:0] idx);
            int unsigned start;
            start = $urandom_range(0, LINE_LAST);
            idx = '0;
            for (int k = 0; k <= LINE_LAST; k++) begin
                idx = 6'((start + k) % (LINE_LAST + 1));
                if (line_written[completed_second][idx]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void check_status(status_t got);
            status_t want;
            results_seen++;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("result word %0d arrived with no request outstanding",
                             results_seen);
                end
                return;
            end
            want = expected_status.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.line_ready !== want.line_ready || got.ready_store !== want.ready_store ||
                got.line_data !== want.line_data || got.free_space !== want.free_space ||
                got.tx_pending !== want.tx_pending) begin
                errors++;
                if (errors <= 10) begin
                    $display("result word %0d: expected txv=%0b txb=%02h rdy=%0b st=%0b",
                             results_seen, want.tx_valid, want.tx_byte, want.line_ready,
                             want.ready_store);
                    $display("    data=%02h free=%0d pend=%0b, got txv=%0b txb=%02h rdy=%0b",
                             want.line_data, want.free_space, want.tx_pending,
                             got.tx_valid, got.tx_byte, got.line_ready);
                    $display("    st=%0b data=%02h free=%0d pend=%0b",
                             got.ready_store, got.line_data, got.free_space, got.tx_pending);
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_status.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_req_type = REQ_TX_RDY;
    logic [7:0] s_rx_byte = '0;
    logic       s_rx_fault = 1'b0;
    logic [7:0] s_push_byte = '0;
    logic [5:0] s_read_index = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic       m_line_ready;
    logic       m_ready_store;
    logic [7:0] m_line_data;
    logic [6:0] m_free_space;
    logic       m_tx_pending;

    line_ring_model model;
    status_t        seen_status;

    // Knobs that shape the traffic of the current phase.
    int unsigned rx_pct = 45;
    int unsigned drain_pct = 30;
    int unsigned long_pct = 5;
    int unsigned gap_max = 0;
    int unsigned ready_on_max = 4;
    int unsigned ready_off_max = 3;
    int unsigned line_left = 0;
    int unsigned ready_run = 0;
    bit          ready_level = 1'b0;

    serial_line_assembler_with_tx_ring_unit #(
        .LINE_LAST(LINE_LAST),
        .TX_DEPTH (TX_DEPTH)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_rx_byte    (s_rx_byte),
        .s_rx_fault   (s_rx_fault),
        .s_push_byte  (s_push_byte),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_valid   (m_tx_valid),
        .m_tx_byte    (m_tx_byte),
        .m_line_ready (m_line_ready),
        .m_ready_store(m_ready_store),
        .m_line_data  (m_line_data),
        .m_free_space (m_free_space),
        .m_tx_pending (m_tx_pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: check every accepted word, then stall in random-length runs unless ready_off_max is 0.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_status.tx_valid    = m_tx_valid;
            seen_status.tx_byte     = m_tx_byte;
            seen_status.line_ready  = m_line_ready;
            seen_status.ready_store = m_ready_store;
            seen_status.line_data   = m_line_data;
            seen_status.free_space  = m_free_space;
            seen_status.tx_pending  = m_tx_pending;
            model.check_status(seen_status);
        end
        if (ready_run == 0) begin
            if (ready_off_max == 0) begin
                ready_level = 1'b1;
                ready_run   = 16;
            end else begin
                ready_level = !ready_level;
                ready_run   = ready_level ? $urandom_range(1, ready_on_max)
                                          : $urandom_range(1, ready_off_max);
            end
        end else begin
            ready_run--;
        end
        m_ready <= ready_level;
    end

    function automatic req_word_t mk_word(logic [2:0] req, logic [7:0] rx, logic err,
                                          logic [7:0] push, logic [5:0] idx);
        req_word_t w;
        w.req_type   = req;
        w.rx_byte    = rx;
        w.rx_fault   = err;
        w.push_byte  = push;
        w.read_index = idx;
        return w;
    endfunction

    task automatic send_word(input req_word_t w);
        s_valid      <= 1'b1;
        s_req_type   <= w.req_type;
        s_rx_byte    <= w.rx_byte;
        s_rx_fault   <= w.rx_fault;
        s_push_byte  <= w.push_byte;
        s_read_index <= w.read_index;
        do @(posedge aclk); while (!s_ready);
        model.note_word(w);
    endtask

    task automatic write_echo(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model.echo_on = value;
    endtask

    // Stop sending and wait until every status word has come back, or the guard runs out.
    task automatic settle();
        int unsigned guard;
        guard = 0;
        s_valid <= 1'b0;
        while (model.outstanding() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (12) @(posedge aclk);
    endtask

    // Line traffic with random content, mixed with ring drains, software requests, faults and unused types.
    task automatic gen_word(output req_word_t w, output bit counted);
        int unsigned roll;
        int unsigned base;
        logic [5:0]  idx;
        w.req_type   = REQ_TX_RDY;
        w.rx_byte    = 8'($urandom);
        w.rx_fault   = 1'b0;
        w.push_byte  = 8'($urandom);
        w.read_index = 6'($urandom);
        counted = 1'b1;
        roll = $urandom_range(0, 99);
        base = rx_pct + drain_pct;
        if (roll < rx_pct) begin
            w.req_type = REQ_RX;
            if (line_left == 0) begin
                w.rx_byte = $urandom_range(0, 1) ? CHAR_CR : CHAR_NUL;
                line_left = ($urandom_range(0, 99) < long_pct) ? $urandom_range(56, 80)
                                                                : $urandom_range(0, 12);
            end else begin
                do w.rx_byte = 8'($urandom_range(1, 255)); while (w.rx_byte == CHAR_CR);
                line_left--;
            end
        end else if (roll < base) begin
            w.req_type = REQ_TX_RDY;
        end else if (roll < base + 8) begin
            w.req_type = REQ_PUSH;
        end else if (roll < base + 14) begin
            w.req_type = REQ_RELEASE;
        end else if (roll < base + 20) begin
            if (model.find_read_index(idx)) begin
                w.req_type   = REQ_READ;
                w.read_index = idx;
            end
        end else if (roll < base + 23) begin
            w.req_type = REQ_RX;
            w.rx_fault = 1'b1;
            counted    = 1'b0;
        end else begin
            w.req_type = REQ_FIRST_UNUSED + 3'($urandom_range(0, 2));
            counted    = 1'b0;
        end
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned done;
        int unsigned burst;
        req_word_t   w;
        bit          counted;
        done  = 0;
        burst = 0;
        while (done < n) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if (gap_max != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                end
            end
            gen_word(w, counted);
            send_word(w);
            burst--;
            if (counted) begin
                done++;
            end
        end
        settle();
    endtask

    initial begin
        model = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_echo(1'b1);

        send_word(mk_word(REQ_TX_RDY, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, 8'hFF, 1'b1, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, 8'h80, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, 8'h7F, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, 8'h01, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, CHAR_CR, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_READ, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_READ, 8'h00, 1'b0, 8'h00, 6'd2));
        send_word(mk_word(REQ_READ, 8'h00, 1'b0, 8'h00, 6'd3));
        // A second line ends while the first is still pending.
        send_word(mk_word(REQ_RX, 8'h41, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RX, CHAR_NUL, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RELEASE, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_RELEASE, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_READ, 8'h00, 1'b0, 8'h00, 6'd1));
        send_word(mk_word(REQ_PUSH, 8'h00, 1'b0, 8'hFF, 6'd0));
        send_word(mk_word(REQ_PUSH, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_FIRST_UNUSED, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_FIRST_UNUSED + 3'd1, 8'h00, 1'b0, 8'h00, 6'd0));
        send_word(mk_word(REQ_FIRST_UNUSED + 3'd2, 8'hFF, 1'b1, 8'hFF, 6'd63));
        send_word(mk_word(REQ_RX, CHAR_CR, 1'b0, 8'h00, 6'd0));
        repeat (5) send_word(mk_word(REQ_TX_RDY, 8'h00, 1'b0, 8'h00, 6'd0));
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    rx_pct = 45; drain_pct = 30; long_pct = 5;
                    gap_max = 8; ready_on_max = 8; ready_off_max = 4;
                    write_echo(1'b1);
                end
                1: begin
                    rx_pct = 45; drain_pct = 30; long_pct = 5;
                    gap_max = 8; ready_on_max = 8; ready_off_max = 4;
                    write_echo(1'b0);
                end
                2: begin
                    // Drains are rare here, so the ring runs full.
                    rx_pct = 70; drain_pct = 5; long_pct = 10;
                    gap_max = 4; ready_on_max = 12; ready_off_max = 12;
                    write_echo(1'b1);
                end
                3: begin
                    rx_pct = 65; drain_pct = 10; long_pct = 60;
                    gap_max = 0; ready_on_max = 1; ready_off_max = 0;
                    write_echo(1'b0);
                end
                4: begin
                    rx_pct = 60; drain_pct = 15; long_pct = 60;
                    gap_max = 12; ready_on_max = 3; ready_off_max = 12;
                    write_echo(1'b1);
                end
                default: begin
                    rx_pct = 40; drain_pct = 35; long_pct = 10;
                    gap_max = 6; ready_on_max = 6; ready_off_max = 6;
                    write_echo(1'b0);
                end
            endcase
            run_phase(RANDOM_PER_PHASE);
        end

        if (model.outstanding() != 0) begin
            $display("%0d expected status words never arrived", model.outstanding());
        end
        if (model.errors == 0 && model.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: serial_line_assembler_with_tx_ring_unit.f
rtl/sla_pkg.sv
rtl/sla_tx_ring.sv
rtl/sla_line_buf.sv
rtl/serial_line_assembler_with_tx_ring_unit.sv
dv/tb_serial_line_assembler_with_tx_ring_unit.sv
